// ===== hw/rtl/tac_pkg.sv =====
package tac_pkg;

   typedef logic [1:0] level_type;
   typedef logic [1:0] site_type;
   typedef logic [1:0] run_type;
   typedef logic [7:0] margin_type;

   localparam level_type LEVEL_NORMAL    = 2'd0;
   localparam level_type LEVEL_SLIGHT    = 2'd1;
   localparam level_type LEVEL_IMPORTANT = 2'd2;
   localparam level_type LEVEL_CRITICAL  = 2'd3;

   localparam site_type SITE_HOME       = 2'd0;
   localparam site_type SITE_SERVER     = 2'd1;
   localparam site_type SITE_GREENHOUSE = 2'd2;

   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;

   typedef logic [1:0] reg_index_type;
   localparam reg_index_type REG_THRESHOLD_LOW  = 2'd0;
   localparam reg_index_type REG_THRESHOLD_HIGH = 2'd1;
   localparam reg_index_type REG_SITE_KIND      = 2'd2;

   localparam int DEG_SCALE = 16;

   function automatic margin_type small_margin(input site_type site);
      margin_type m;
      case (site)
         SITE_HOME:   m = margin_type'(2 * DEG_SCALE);
         SITE_SERVER: m = margin_type'(3 * DEG_SCALE);
         default:     m = margin_type'(5 * DEG_SCALE);
      endcase
      return m;
   endfunction

   function automatic margin_type large_margin(input site_type site);
      margin_type m;
      case (site) inside
         SITE_HOME, SITE_SERVER: m = margin_type'(5 * DEG_SCALE);
         default:                m = margin_type'(6 * DEG_SCALE);
      endcase
      return m;
   endfunction

endpackage

// ===== hw/rtl/tac_req_if.sv =====
interface tac_req_if #(
   parameter int TEMP_WIDTH = 12
);
   logic                         valid;
   logic                         ready;
   logic signed [TEMP_WIDTH-1:0] sample_temp;

   modport source (output valid, output sample_temp, input ready);
   modport sink (input valid, input sample_temp, output ready);
endinterface

// ===== hw/rtl/tac_rsp_if.sv =====
interface tac_rsp_if #(
   parameter int TEMP_WIDTH  = 12,
   parameter int ALERT_WIDTH = 16,
   parameter int COUNT_WIDTH = 24
);
   logic                                     valid;
   logic                                     ready;
   logic [1:0]                               level;
   logic                                     alert_fired;
   logic [ALERT_WIDTH-1:0]                   slight_alerts;
   logic [ALERT_WIDTH-1:0]                   important_alerts;
   logic [ALERT_WIDTH-1:0]                   critical_alerts;
   logic signed [TEMP_WIDTH-1:0]             lowest_temp;
   logic signed [TEMP_WIDTH-1:0]             highest_temp;
   logic signed [TEMP_WIDTH+COUNT_WIDTH-1:0] temp_total;
   logic [COUNT_WIDTH-1:0]                   samples_seen;

   modport source (
      output valid, output level, output alert_fired, output slight_alerts,
      output important_alerts, output critical_alerts, output lowest_temp,
      output highest_temp, output temp_total, output samples_seen,
      input ready
   );
   modport sink (
      input valid, input level, input alert_fired, input slight_alerts,
      input important_alerts, input critical_alerts, input lowest_temp,
      input highest_temp, input temp_total, input samples_seen,
      output ready
   );
endinterface

// ===== hw/rtl/tac_classify.sv =====
module tac_classify
   import tac_pkg::*;
#(
   parameter int TEMP_WIDTH = 12
) (
   input  logic signed [TEMP_WIDTH-1:0] temp,
   input  logic signed [TEMP_WIDTH-1:0] threshold_low,
   input  logic signed [TEMP_WIDTH-1:0] threshold_high,
   input  site_type                     site_kind,
   output level_type                    level
);

   localparam int EXT_WIDTH = TEMP_WIDTH + 2;
   localparam int PAD_WIDTH = EXT_WIDTH - $bits(margin_type);

   logic signed [EXT_WIDTH-1:0] t_ext;
   logic signed [EXT_WIDTH-1:0] lo_ext;
   logic signed [EXT_WIDTH-1:0] hi_ext;
   logic signed [EXT_WIDTH-1:0] small_ext;
   logic signed [EXT_WIDTH-1:0] large_ext;
   logic signed [EXT_WIDTH-1:0] lo_small;
   logic signed [EXT_WIDTH-1:0] lo_large;
   logic signed [EXT_WIDTH-1:0] hi_small;
   logic signed [EXT_WIDTH-1:0] hi_large;

   always_comb begin
      t_ext     = EXT_WIDTH'(temp);
      lo_ext    = EXT_WIDTH'(threshold_low);
      hi_ext    = EXT_WIDTH'(threshold_high);
      small_ext = $signed({{PAD_WIDTH{1'b0}}, small_margin(site_kind)});
      large_ext = $signed({{PAD_WIDTH{1'b0}}, large_margin(site_kind)});
      lo_small  = lo_ext - small_ext;
      lo_large  = lo_ext - large_ext;
      hi_small  = hi_ext + small_ext;
      hi_large  = hi_ext + large_ext;

      if (t_ext >= lo_ext && t_ext <= hi_ext) begin
         level = LEVEL_NORMAL;
      end else if ((t_ext < lo_ext && t_ext >= lo_small) ||
                   (t_ext > hi_ext && t_ext <= hi_small)) begin
         level = LEVEL_SLIGHT;
      end else if ((t_ext > hi_small && t_ext <= hi_large) ||
                   (t_ext < lo_small && t_ext >= lo_large)) begin
         level = LEVEL_IMPORTANT;
      end else begin
         level = LEVEL_CRITICAL;
      end
   end

endmodule

// ===== hw/rtl/temperature_alarm_classifier_top.sv =====
// Channel   Direction  Handshake            Payload
// req       in         req.valid/req.ready  sample_temp
// rsp       out        rsp.valid/rsp.ready  level, alert_fired, alert totals, min/max/sum/count
// csr       in         APB psel/penable     threshold_low, threshold_high, site_kind
//
// Each sample passes through one input register, then the classifier and the statistics
// update in front of the result register.
// One sample is accepted per cycle while rsp takes results; the input register accepts while the result register
// drains, so a stall on rsp backs up to req only after both stages are full.
// Synchronous reset returns the configuration, the run counters and all statistics to
// their reset values.
module temperature_alarm_classifier_top
   import tac_pkg::*;
#(
   parameter int TEMP_WIDTH  = 12,
   parameter int RUN_LENGTH  = 3,
   parameter int ALERT_WIDTH = 16,
   parameter int COUNT_WIDTH = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   tac_req_if.sink                   req,
   tac_rsp_if.source                 rsp,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   localparam int SUM_WIDTH = TEMP_WIDTH + COUNT_WIDTH;

   localparam logic signed [TEMP_WIDTH-1:0] MIN_RESET = {1'b0, {(TEMP_WIDTH-1){1'b1}}};
   localparam logic signed [TEMP_WIDTH-1:0] THRESHOLD_HIGH_RESET = TEMP_WIDTH'(400);
   localparam logic signed [SUM_WIDTH-1:0]  SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_WIDTH-1:0]  SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};
   localparam run_type RUN_LIMIT = run_type'(RUN_LENGTH);

   logic signed [TEMP_WIDTH-1:0] threshold_low_ff;
   logic signed [TEMP_WIDTH-1:0] threshold_high_ff;
   site_type                     site_kind_ff;

   logic                         stage_valid_ff;
   logic signed [TEMP_WIDTH-1:0] stage_temp_ff;
   logic                         rsp_valid_ff;
   level_type                    level_ff;
   level_type                    level_in;
   logic                         fired_ff;
   logic                         fired_in;

   run_type                      run_slight_ff, run_slight_in;
   run_type                      run_important_ff, run_important_in;
   run_type                      run_critical_ff, run_critical_in;
   logic [ALERT_WIDTH-1:0]       total_slight_ff, total_slight_in;
   logic [ALERT_WIDTH-1:0]       total_important_ff, total_important_in;
   logic [ALERT_WIDTH-1:0]       total_critical_ff, total_critical_in;
   logic signed [TEMP_WIDTH-1:0] min_ff, min_in;
   logic signed [TEMP_WIDTH-1:0] max_ff, max_in;
   logic signed [SUM_WIDTH-1:0]  sum_ff, sum_in;
   logic [COUNT_WIDTH-1:0]       count_ff, count_in;

   logic                         out_free;
   logic                         advance;
   logic                         csr_write;
   reg_index_type                csr_index;
   run_type                      inc_slight, inc_important, inc_critical;
   logic signed [SUM_WIDTH:0]    sum_wide;

   assign pready    = 1'b1;
   assign csr_index = paddr[CSR_ADDR_WIDTH-1:2];
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      unique case (csr_index)
         REG_THRESHOLD_LOW:  prdata = CSR_DATA_WIDTH'($unsigned(threshold_low_ff));
         REG_THRESHOLD_HIGH: prdata = CSR_DATA_WIDTH'($unsigned(threshold_high_ff));
         REG_SITE_KIND:      prdata = CSR_DATA_WIDTH'(site_kind_ff);
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_low_ff  <= '0;
         threshold_high_ff <= THRESHOLD_HIGH_RESET;
         site_kind_ff      <= SITE_HOME;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_THRESHOLD_LOW:  threshold_low_ff  <= pwdata[TEMP_WIDTH-1:0];
            REG_THRESHOLD_HIGH: threshold_high_ff <= pwdata[TEMP_WIDTH-1:0];
            REG_SITE_KIND:      site_kind_ff      <= pwdata[1:0];
            default:            ;
         endcase
      end
   end

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign advance   = stage_valid_ff && out_free;
   assign req.ready = !stage_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req.ready) begin
         stage_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         stage_temp_ff <= req.sample_temp;
      end
   end

   tac_classify #(
      .TEMP_WIDTH (TEMP_WIDTH)
   ) u_classify (
      .temp           (stage_temp_ff),
      .threshold_low  (threshold_low_ff),
      .threshold_high (threshold_high_ff),
      .site_kind      (site_kind_ff),
      .level          (level_in)
   );

   always_comb begin
      inc_slight    = run_slight_ff + run_type'(1);
      inc_important = run_important_ff + run_type'(1);
      inc_critical  = run_critical_ff + run_type'(1);

      run_slight_in      = (level_in == LEVEL_SLIGHT) ? inc_slight : '0;
      run_important_in   = (level_in == LEVEL_IMPORTANT) ? inc_important : '0;
      run_critical_in    = (level_in == LEVEL_CRITICAL) ? inc_critical : '0;
      total_slight_in    = total_slight_ff;
      total_important_in = total_important_ff;
      total_critical_in  = total_critical_ff;
      fired_in           = 1'b0;

      if (run_slight_in >= RUN_LIMIT) begin
         run_slight_in = '0;
         fired_in      = 1'b1;
         if (total_slight_ff != '1) begin
            total_slight_in = total_slight_ff + ALERT_WIDTH'(1);
         end
      end else if (run_important_in >= RUN_LIMIT) begin
         run_important_in = '0;
         fired_in         = 1'b1;
         if (total_important_ff != '1) begin
            total_important_in = total_important_ff + ALERT_WIDTH'(1);
         end
      end else if (run_critical_in >= RUN_LIMIT) begin
         run_critical_in = '0;
         fired_in        = 1'b1;
         if (total_critical_ff != '1) begin
            total_critical_in = total_critical_ff + ALERT_WIDTH'(1);
         end
      end

      max_in = (stage_temp_ff > max_ff) ? stage_temp_ff : max_ff;
      min_in = (stage_temp_ff < min_ff) ? stage_temp_ff : min_ff;

      sum_wide = (SUM_WIDTH+1)'(sum_ff) + (SUM_WIDTH+1)'(stage_temp_ff);
      if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
         sum_in = sum_wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
      end else begin
         sum_in = sum_wide[SUM_WIDTH-1:0];
      end

      count_in = (count_ff == '1) ? count_ff : count_ff + COUNT_WIDTH'(1);
   end

   // The statistics registers change only when a result loads, so they always
   // hold the values that belong to the result on display.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff       <= 1'b0;
         run_slight_ff      <= '0;
         run_important_ff   <= '0;
         run_critical_ff    <= '0;
         total_slight_ff    <= '0;
         total_important_ff <= '0;
         total_critical_ff  <= '0;
         min_ff             <= MIN_RESET;
         max_ff             <= '0;
         sum_ff             <= '0;
         count_ff           <= '0;
      end else begin
         if (out_free) begin
            rsp_valid_ff <= stage_valid_ff;
         end
         if (advance) begin
            run_slight_ff      <= run_slight_in;
            run_important_ff   <= run_important_in;
            run_critical_ff    <= run_critical_in;
            total_slight_ff    <= total_slight_in;
            total_important_ff <= total_important_in;
            total_critical_ff  <= total_critical_in;
            min_ff             <= min_in;
            max_ff             <= max_in;
            sum_ff             <= sum_in;
            count_ff           <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         level_ff <= level_in;
         fired_ff <= fired_in;
      end
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.level            = level_ff;
   assign rsp.alert_fired      = fired_ff;
   assign rsp.slight_alerts    = total_slight_ff;
   assign rsp.important_alerts = total_important_ff;
   assign rsp.critical_alerts  = total_critical_ff;
   assign rsp.lowest_temp      = min_ff;
   assign rsp.highest_temp     = max_ff;
   assign rsp.temp_total       = sum_ff;
   assign rsp.samples_seen     = count_ff;

   a_fired_not_normal : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && fired_ff |-> level_ff != LEVEL_NORMAL)
      else $error("alert fired on a normal sample");

   a_one_run_active : assert property (@(posedge clock) disable iff (reset)
      $countones({run_slight_ff != '0, run_important_ff != '0, run_critical_ff != '0}) <= 1)
      else $error("more than one run counter active");

   a_stats_hold : assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(count_ff) && $stable(sum_ff))
      else $error("statistics changed without a result transfer");

   a_min_le_max : assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 |-> min_ff <= max_ff)
      else $error("running minimum above running maximum");

   a_run_bound : assert property (@(posedge clock) disable iff (reset)
      run_slight_ff < RUN_LIMIT && run_important_ff < RUN_LIMIT && run_critical_ff < RUN_LIMIT)
      else $error("run counter reached its limit without restarting");

endmodule
